### hw/rtl/tmpg_pkg.sv
// ============================================================================
// tmpg_pkg
// Shared types, constants and helper functions of the torus mesh point
// generator.
// ============================================================================
package tmpg_pkg;

    // Largest segment count that the mesh supports around either circle.
    localparam logic [8:0] MAX_SEGMENTS = 9'd256;
    localparam logic [8:0] MIN_SEGMENTS = 9'd3;

    // pi/2 in Q30 and one in Q30.
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;

    // Series length and latencies of the sine/cosine unit.
    localparam int TAYLOR_TERMS = 7;
    localparam int TERM_LAT     = 3;
    localparam int SC_LAT       = 2 + TAYLOR_TERMS * TERM_LAT + 1;

    // Divisors of the successive Taylor terms.
    localparam int SIN_DIV [0:6] = '{6, 20, 42, 72, 110, 156, 210};
    localparam int COS_DIV [0:6] = '{2, 12, 30, 56, 90, 132, 182};

    // Configuration register indexes.
    localparam logic [7:0] REG_RING_RADIUS   = 8'd0;
    localparam logic [7:0] REG_TUBE_RADIUS   = 8'd1;
    localparam logic [7:0] REG_RING_SEGMENTS = 8'd2;
    localparam logic [7:0] REG_TUBE_SEGMENTS = 8'd3;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    // Grid indexes that travel beside the trigonometry pipeline.
    typedef struct packed {
        logic [7:0] i;
        logic [7:0] i1;
        logic [7:0] j;
        logic [7:0] j1;
    } side_t;

    function automatic int trailing_zeros(input int v);
        int n;
        n = 0;
        for (int b = 0; b < 8; b++)
        begin
            if (n == b && v[b] == 1'b0)
            begin
                n = b + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [8:0] eff_count(input logic [8:0] n);
        logic [8:0] r;
        r = n;
        if (r < MIN_SEGMENTS)
        begin
            r = MIN_SEGMENTS;
        end
        if (r > MAX_SEGMENTS)
        begin
            r = MAX_SEGMENTS;
        end
        return r;
    endfunction

    // Clamp a Q30 series sum to [0, 1] and round it to Q1.14, half up.
    function automatic logic [14:0] unit_to_q14(input logic signed [34:0] acc);
        logic [30:0] cl;
        logic [31:0] sum;
        if (acc < 0)
        begin
            cl = '0;
        end
        else if (acc > $signed({4'b0, ONE_Q30}))
        begin
            cl = ONE_Q30;
        end
        else
        begin
            cl = acc[30:0];
        end
        sum = {1'b0, cl} + 32'd32768;
        return sum[30:16];
    endfunction

    // Shift right by 14, rounding half away from zero.
    function automatic logic signed [35:0] round_q14(input logic signed [35:0] v);
        logic [35:0] mag;
        mag = v[35] ? 36'(-v) : 36'(v);
        mag = (mag + 36'd8192) >> 14;
        return v[35] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [35:0] sat36(input logic signed [35:0] v,
                                                 input logic signed [35:0] lo,
                                                 input logic signed [35:0] hi);
        logic signed [35:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

### hw/rtl/torus_mesh_point_generator.sv
// ============================================================================
// torus_mesh_point_generator
// Vertex position, unit normal and quad corner indexes of one torus grid
// point, fully pipelined.
// ============================================================================
// A request is taken at every rising edge with start high; busy stays low,
// since the pipeline accepts a new grid point in every cycle. Each request
// gives exactly one result, shown for one cycle with done high. A request
// passes in order an input register, the index reduction divider, the phase
// divider (two quotient bits a stage), the sine/cosine series (seven terms
// of three stages each) and four stages for the normal, the position and
// the corner indexes.
// Results leave in request order; the receiver cannot stall, so nothing
// ever waits inside the pipeline.
// The configuration channel is always ready. Registers may be written only
// while no request is in flight. Reset empties the pipeline and loads the
// register defaults: ring radius 1.0, tube radius 0.25, three segments each.
// ============================================================================
module torus_mesh_point_generator
    import tmpg_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         ring_index,
    input  logic [7:0]         tube_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [17:0] pos_x,
    output logic signed [17:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [15:0]        corner_a,
    output logic [15:0]        corner_b,
    output logic [15:0]        corner_c,
    output logic [15:0]        corner_d
);

    localparam int MOD_STAGES = 4;
    localparam int PH_STAGES  = (ANGLE_BITS + 2) / 2;
    localparam int PH_W       = ANGLE_BITS + 10;
    localparam int SIDE_DLY   = PH_STAGES + SC_LAT;
    localparam int LATENCY    = 1 + MOD_STAGES + PH_STAGES + SC_LAT + 4;

    // Configuration registers.
    logic [15:0] ring_radius_reg;
    logic [15:0] tube_radius_reg;
    logic [8:0]  ring_segments_reg;
    logic [8:0]  tube_segments_reg;
    logic [8:0]  m_eff;
    logic [8:0]  n_eff;

    logic        v0_reg;
    logic [7:0]  ri_reg;
    logic [7:0]  ti_reg;

    logic        mod_valid;
    logic [7:0]  i_red;
    logic [7:0]  j_red;
    side_t       side_next;
    side_t       side_reg [0:SIDE_DLY-1];

    logic                  ph_valid;
    logic [ANGLE_BITS:0]   ph_u;
    logic [ANGLE_BITS:0]   ph_v;
    logic                  sc_valid;
    logic signed [15:0]    su;
    logic signed [15:0]    cu;
    logic signed [15:0]    sv;
    logic signed [15:0]    cv;

    // Normal stage 1.
    logic               n1_valid_reg;
    logic signed [31:0] cvcu_reg;
    logic signed [31:0] cvsu_reg;
    logic signed [15:0] sv1_reg;
    logic signed [15:0] cu1_reg;
    logic signed [15:0] su1_reg;
    logic [16:0]        in_reg;
    logic [16:0]        i1n_reg;
    logic [7:0]         j1a_reg;
    logic [7:0]         j1b_reg;

    // Normal stage 2.
    logic               n2_valid_reg;
    logic signed [15:0] nx2_reg;
    logic signed [15:0] nx2_next;
    logic signed [15:0] ny2_reg;
    logic signed [15:0] ny2_next;
    logic signed [15:0] nz2_reg;
    logic signed [15:0] cu2_reg;
    logic signed [15:0] su2_reg;
    logic [15:0]        ca2_reg;
    logic [15:0]        cb2_reg;
    logic [15:0]        cc2_reg;
    logic [15:0]        cd2_reg;

    // Position stage 1.
    logic               p1_valid_reg;
    logic signed [32:0] rcu_reg;
    logic signed [32:0] rsu_reg;
    logic signed [32:0] tnx_reg;
    logic signed [32:0] tny_reg;
    logic signed [32:0] tnz_reg;
    logic signed [15:0] nx3_reg;
    logic signed [15:0] ny3_reg;
    logic signed [15:0] nz3_reg;
    logic [15:0]        ca3_reg;
    logic [15:0]        cb3_reg;
    logic [15:0]        cc3_reg;
    logic [15:0]        cd3_reg;

    // Output registers.
    logic               done_reg;
    logic signed [17:0] pos_x_reg;
    logic signed [17:0] pos_x_next;
    logic signed [17:0] pos_y_reg;
    logic signed [17:0] pos_y_next;
    logic signed [16:0] pos_z_reg;
    logic signed [16:0] pos_z_next;
    logic signed [15:0] normal_x_reg;
    logic signed [15:0] normal_y_reg;
    logic signed [15:0] normal_z_reg;
    logic [15:0]        corner_a_reg;
    logic [15:0]        corner_b_reg;
    logic [15:0]        corner_c_reg;
    logic [15:0]        corner_d_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign m_eff     = eff_count(ring_segments_reg);
    assign n_eff     = eff_count(tube_segments_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_radius_reg   <= 16'd256;
            tube_radius_reg   <= 16'd64;
            ring_segments_reg <= 9'd3;
            tube_segments_reg <= 9'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RING_RADIUS:   ring_radius_reg   <= cfg_data;
                REG_TUBE_RADIUS:   tube_radius_reg   <= cfg_data;
                REG_RING_SEGMENTS: ring_segments_reg <= cfg_data[8:0];
                REG_TUBE_SEGMENTS: tube_segments_reg <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    // Reduce the indexes below their segment counts.
    tmpg_div #(
        .NUM_W (8),
        .DEN_W (9),
        .QUO_W (8),
        .STEPS (2)
    ) u_ring_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (v0_reg),
        .num       (ri_reg),
        .den       (m_eff),
        .res_valid (mod_valid),
        .quo       (),
        .rem       (i_red)
    );

    tmpg_div #(
        .NUM_W (8),
        .DEN_W (9),
        .QUO_W (8),
        .STEPS (2)
    ) u_tube_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (v0_reg),
        .num       (ti_reg),
        .den       (n_eff),
        .res_valid (),
        .quo       (),
        .rem       (j_red)
    );

    // Phase = round(index * 2^ANGLE_BITS / count), ties up.
    tmpg_div #(
        .NUM_W (PH_W),
        .DEN_W (10),
        .QUO_W (ANGLE_BITS + 1),
        .STEPS (2)
    ) u_ring_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (mod_valid),
        .num       (PH_W'({i_red, {(ANGLE_BITS + 1){1'b0}}}) + PH_W'(m_eff)),
        .den       ({m_eff, 1'b0}),
        .res_valid (ph_valid),
        .quo       (ph_u),
        .rem       ()
    );

    tmpg_div #(
        .NUM_W (PH_W),
        .DEN_W (10),
        .QUO_W (ANGLE_BITS + 1),
        .STEPS (2)
    ) u_tube_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (mod_valid),
        .num       (PH_W'({j_red, {(ANGLE_BITS + 1){1'b0}}}) + PH_W'(n_eff)),
        .den       ({n_eff, 1'b0}),
        .res_valid (),
        .quo       (ph_v),
        .rem       ()
    );

    tmpg_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_ring_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (ph_valid),
        .arg_phase (ph_u[ANGLE_BITS-1:0]),
        .res_valid (sc_valid),
        .res_sin   (su),
        .res_cos   (cu)
    );

    tmpg_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_tube_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (ph_valid),
        .arg_phase (ph_v[ANGLE_BITS-1:0]),
        .res_valid (),
        .res_sin   (sv),
        .res_cos   (cv)
    );

    // Next steps wrap at the segment counts.
    always_comb
    begin
        side_next.i  = i_red;
        side_next.j  = j_red;
        side_next.i1 = ({1'b0, i_red} + 9'd1 == m_eff) ? 8'd0 : i_red + 8'd1;
        side_next.j1 = ({1'b0, j_red} + 9'd1 == n_eff) ? 8'd0 : j_red + 8'd1;
    end

    always_comb
    begin : normal_logic
        logic signed [35:0] rnx;
        logic signed [35:0] rny;
        rnx      = round_q14(36'(cvcu_reg));
        rny      = round_q14(36'(cvsu_reg));
        nx2_next = rnx[15:0];
        ny2_next = rny[15:0];
    end

    always_comb
    begin : position_logic
        logic signed [35:0] rx;
        logic signed [35:0] ry;
        logic signed [35:0] rz;
        rx = sat36(round_q14(36'(rcu_reg) + 36'(tnx_reg)), -36'sd131072, 36'sd131071);
        ry = sat36(round_q14(36'(rsu_reg) + 36'(tny_reg)), -36'sd131072, 36'sd131071);
        rz = sat36(round_q14(36'(tnz_reg)), -36'sd65536, 36'sd65535);
        pos_x_next = rx[17:0];
        pos_y_next = ry[17:0];
        pos_z_next = rz[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            v0_reg       <= start && !busy;
            n1_valid_reg <= sc_valid;
            n2_valid_reg <= n1_valid_reg;
            p1_valid_reg <= n2_valid_reg;
            done_reg     <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ri_reg      <= ring_index;
        ti_reg      <= tube_index;
        side_reg[0] <= side_next;
        for (int k = 1; k < SIDE_DLY; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end

        cvcu_reg <= cv * cu;
        cvsu_reg <= cv * su;
        sv1_reg  <= sv;
        cu1_reg  <= cu;
        su1_reg  <= su;
        in_reg   <= side_reg[SIDE_DLY-1].i * n_eff;
        i1n_reg  <= side_reg[SIDE_DLY-1].i1 * n_eff;
        j1a_reg  <= side_reg[SIDE_DLY-1].j;
        j1b_reg  <= side_reg[SIDE_DLY-1].j1;

        nx2_reg <= nx2_next;
        ny2_reg <= ny2_next;
        nz2_reg <= sv1_reg;
        cu2_reg <= cu1_reg;
        su2_reg <= su1_reg;
        ca2_reg <= 16'(in_reg + 17'(j1a_reg));
        cb2_reg <= 16'(i1n_reg + 17'(j1a_reg));
        cc2_reg <= 16'(i1n_reg + 17'(j1b_reg));
        cd2_reg <= 16'(in_reg + 17'(j1b_reg));

        rcu_reg <= $signed({1'b0, ring_radius_reg}) * cu2_reg;
        rsu_reg <= $signed({1'b0, ring_radius_reg}) * su2_reg;
        tnx_reg <= $signed({1'b0, tube_radius_reg}) * nx2_reg;
        tny_reg <= $signed({1'b0, tube_radius_reg}) * ny2_reg;
        tnz_reg <= $signed({1'b0, tube_radius_reg}) * nz2_reg;
        nx3_reg <= nx2_reg;
        ny3_reg <= ny2_reg;
        nz3_reg <= nz2_reg;
        ca3_reg <= ca2_reg;
        cb3_reg <= cb2_reg;
        cc3_reg <= cc2_reg;
        cd3_reg <= cd2_reg;

        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        pos_z_reg    <= pos_z_next;
        normal_x_reg <= nx3_reg;
        normal_y_reg <= ny3_reg;
        normal_z_reg <= nz3_reg;
        corner_a_reg <= ca3_reg;
        corner_b_reg <= cb3_reg;
        corner_c_reg <= cc3_reg;
        corner_d_reg <= cd3_reg;
    end

    assign done     = done_reg;
    assign pos_x    = pos_x_reg;
    assign pos_y    = pos_y_reg;
    assign pos_z    = pos_z_reg;
    assign normal_x = normal_x_reg;
    assign normal_y = normal_y_reg;
    assign normal_z = normal_z_reg;
    assign corner_a = corner_a_reg;
    assign corner_b = corner_b_reg;
    assign corner_c = corner_c_reg;
    assign corner_d = corner_d_reg;

`ifndef SYNTHESIS
    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted request produced no result");

    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    a_normal_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
                  normal_y >= -16'sd16384 && normal_y <= 16'sd16384 &&
                  normal_z >= -16'sd16384 && normal_z <= 16'sd16384))
        else $error("normal component outside unit range");
`endif

endmodule

### hw/rtl/tmpg_div.sv
// ============================================================================
// tmpg_div
// Pipelined restoring divider: a few quotient bits are resolved in every
// stage, and one request can enter in every cycle.
// ============================================================================
module tmpg_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 9,
    parameter int QUO_W = 8,
    parameter int STEPS = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             arg_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             res_valid,
    output logic [QUO_W-1:0] quo,
    output logic [NUM_W-1:0] rem
);

    localparam int STAGES = (QUO_W + STEPS - 1) / STEPS;
    localparam int CMP_W  = NUM_W + DEN_W + QUO_W;

    logic             stg_valid [0:STAGES];
    logic [NUM_W-1:0] stg_rem   [0:STAGES];
    logic [QUO_W-1:0] stg_quo   [0:STAGES];
    logic [DEN_W-1:0] stg_den   [0:STAGES];

    assign stg_valid[0] = arg_valid;
    assign stg_rem[0]   = num;
    assign stg_quo[0]   = '0;
    assign stg_den[0]   = den;

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic             valid_reg;
            logic [NUM_W-1:0] rem_reg;
            logic [NUM_W-1:0] rem_next;
            logic [QUO_W-1:0] quo_reg;
            logic [QUO_W-1:0] quo_next;
            logic [DEN_W-1:0] den_reg;

            always_comb
            begin : step_logic
                logic [CMP_W-1:0] r;
                logic [CMP_W-1:0] d;
                logic [QUO_W-1:0] q;
                r = CMP_W'(stg_rem[s]);
                q = stg_quo[s];
                d = '0;
                for (int k = 0; k < STEPS; k++)
                begin
                    if (s * STEPS + k < QUO_W)
                    begin
                        d = CMP_W'(stg_den[s]) << (QUO_W - 1 - (s * STEPS + k));
                        if (r >= d)
                        begin
                            r = r - d;
                            q[QUO_W - 1 - (s * STEPS + k)] = 1'b1;
                        end
                    end
                end
                rem_next = r[NUM_W-1:0];
                quo_next = q;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg <= 1'b0;
                end
                else
                begin
                    valid_reg <= stg_valid[s];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                den_reg <= stg_den[s];
            end

            assign stg_valid[s+1] = valid_reg;
            assign stg_rem[s+1]   = rem_reg;
            assign stg_quo[s+1]   = quo_reg;
            assign stg_den[s+1]   = den_reg;
        end
    endgenerate

    assign res_valid = stg_valid[STAGES];
    assign quo       = stg_quo[STAGES];
    assign rem       = stg_rem[STAGES];

endmodule

### hw/rtl/tmpg_term.sv
// ============================================================================
// tmpg_term
// One Taylor series term: t' = ((t * x2) >> 30) / DIVISOR, added to or
// subtracted from the running sum, over three register stages.
// ============================================================================
module tmpg_term
    import tmpg_pkg::*;
#(
    parameter int DIVISOR  = 6,
    parameter bit SUBTRACT = 1'b1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               arg_valid,
    input  logic [31:0]        arg_t,
    input  logic [31:0]        arg_x2,
    input  logic signed [34:0] arg_acc,
    output logic               res_valid,
    output logic [31:0]        res_t,
    output logic [31:0]        res_x2,
    output logic signed [34:0] res_acc
);

    // The divisor splits into a shift and an odd factor; the odd factor is
    // divided by a reciprocal product that is low by at most one.
    localparam int         SHIFT = trailing_zeros(DIVISOR);
    localparam int         ODD   = DIVISOR >> SHIFT;
    localparam logic [7:0] ODD_V = 8'(ODD);
    localparam logic [34:0] RECIP = 35'((64'd1 << 33) / 64'(ODD));

    logic               v1_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        x2_1_reg;
    logic signed [34:0] acc1_reg;

    logic               v2_reg;
    logic [32:0]        q0_reg;
    logic [32:0]        q0_next;
    logic [32:0]        as_reg;
    logic [32:0]        as_next;
    logic [31:0]        x2_2_reg;
    logic signed [34:0] acc2_reg;

    logic               v3_reg;
    logic [31:0]        t_reg;
    logic [31:0]        t_next;
    logic [31:0]        x2_3_reg;
    logic signed [34:0] acc3_reg;
    logic signed [34:0] acc3_next;

    always_comb
    begin : recip_logic
        logic [67:0] qprod;
        as_next = prod_reg[62:30] >> SHIFT;
        qprod   = as_next * RECIP;
        q0_next = qprod[65:33];
    end

    always_comb
    begin : fix_logic
        logic [40:0] chk;
        logic [32:0] r;
        logic [32:0] q;
        chk = q0_reg * ODD_V;
        r   = as_reg - chk[32:0];
        q   = q0_reg + 33'(r >= 33'(ODD_V));
        t_next = q[31:0];
        if (SUBTRACT)
        begin
            acc3_next = acc2_reg - $signed({2'b00, q});
        end
        else
        begin
            acc3_next = acc2_reg + $signed({2'b00, q});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= arg_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= arg_t * arg_x2;
        x2_1_reg <= arg_x2;
        acc1_reg <= arg_acc;
        q0_reg   <= q0_next;
        as_reg   <= as_next;
        x2_2_reg <= x2_1_reg;
        acc2_reg <= acc1_reg;
        t_reg    <= t_next;
        x2_3_reg <= x2_2_reg;
        acc3_reg <= acc3_next;
    end

    assign res_valid = v3_reg;
    assign res_t     = t_reg;
    assign res_x2    = x2_3_reg;
    assign res_acc   = acc3_reg;

endmodule

### hw/rtl/tmpg_sincos.sv
// ============================================================================
// tmpg_sincos
// Sine and cosine of a phase given in fractions of a turn, in Q1.14, by a
// Taylor series over the first quadrant and the quadrant symmetries.
// ============================================================================
module tmpg_sincos
    import tmpg_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  arg_valid,
    input  logic [ANGLE_BITS-1:0] arg_phase,
    output logic                  res_valid,
    output logic signed [15:0]    res_sin,
    output logic signed [15:0]    res_cos
);

    localparam int QDLY = 2 + TAYLOR_TERMS * TERM_LAT;

    logic               vx_reg;
    logic [30:0]        x_reg;
    logic [30:0]        x_next;
    logic               vx2_reg;
    logic [30:0]        xb_reg;
    logic [31:0]        x2_reg;
    logic [31:0]        x2_next;
    quad_t              quad_reg [0:QDLY-1];

    logic               s_valid [0:TAYLOR_TERMS];
    logic [31:0]        s_t     [0:TAYLOR_TERMS];
    logic [31:0]        s_x2    [0:TAYLOR_TERMS];
    logic signed [34:0] s_acc   [0:TAYLOR_TERMS];
    logic               c_valid [0:TAYLOR_TERMS];
    logic [31:0]        c_t     [0:TAYLOR_TERMS];
    logic [31:0]        c_x2    [0:TAYLOR_TERMS];
    logic signed [34:0] c_acc   [0:TAYLOR_TERMS];

    logic               out_valid_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] sin_next;
    logic signed [15:0] cos_reg;
    logic signed [15:0] cos_next;

    // Map the low phase bits onto [0, pi/2) in Q30 radians.
    always_comb
    begin : angle_logic
        logic [ANGLE_BITS+28:0] xprod;
        xprod  = arg_phase[ANGLE_BITS-3:0] * HALF_PI_Q30;
        x_next = xprod[ANGLE_BITS+28:ANGLE_BITS-2];
    end

    always_comb
    begin : square_logic
        logic [61:0] sq;
        sq      = x_reg * x_reg;
        x2_next = sq[61:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg        <= 1'b0;
            vx2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vx_reg        <= arg_valid;
            vx2_reg       <= vx_reg;
            out_valid_reg <= s_valid[TAYLOR_TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        xb_reg      <= x_reg;
        x2_reg      <= x2_next;
        quad_reg[0] <= quad_t'(arg_phase[ANGLE_BITS-1:ANGLE_BITS-2]);
        for (int k = 1; k < QDLY; k++)
        begin
            quad_reg[k] <= quad_reg[k-1];
        end
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign s_valid[0] = vx2_reg;
    assign s_t[0]     = {1'b0, xb_reg};
    assign s_x2[0]    = x2_reg;
    assign s_acc[0]   = $signed({4'b0000, xb_reg});
    assign c_valid[0] = vx2_reg;
    assign c_t[0]     = {1'b0, ONE_Q30};
    assign c_x2[0]    = x2_reg;
    assign c_acc[0]   = $signed({4'b0000, ONE_Q30});

    genvar k;
    generate
        for (k = 0; k < TAYLOR_TERMS; k++)
        begin : g_term
            tmpg_term #(
                .DIVISOR  (SIN_DIV[k]),
                .SUBTRACT (k % 2 == 0)
            ) u_sin_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .arg_valid (s_valid[k]),
                .arg_t     (s_t[k]),
                .arg_x2    (s_x2[k]),
                .arg_acc   (s_acc[k]),
                .res_valid (s_valid[k+1]),
                .res_t     (s_t[k+1]),
                .res_x2    (s_x2[k+1]),
                .res_acc   (s_acc[k+1])
            );

            tmpg_term #(
                .DIVISOR  (COS_DIV[k]),
                .SUBTRACT (k % 2 == 0)
            ) u_cos_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .arg_valid (c_valid[k]),
                .arg_t     (c_t[k]),
                .arg_x2    (c_x2[k]),
                .arg_acc   (c_acc[k]),
                .res_valid (c_valid[k+1]),
                .res_t     (c_t[k+1]),
                .res_x2    (c_x2[k+1]),
                .res_acc   (c_acc[k+1])
            );
        end
    endgenerate

    always_comb
    begin : quadrant_logic
        logic signed [15:0] s;
        logic signed [15:0] c;
        s = $signed({1'b0, unit_to_q14(s_acc[TAYLOR_TERMS])});
        c = $signed({1'b0, unit_to_q14(c_acc[TAYLOR_TERMS])});
        case (quad_reg[QDLY-1])
            QUAD_I:
            begin
                sin_next = s;
                cos_next = c;
            end
            QUAD_II:
            begin
                sin_next = c;
                cos_next = -s;
            end
            QUAD_III:
            begin
                sin_next = -s;
                cos_next = -c;
            end
            default:
            begin
                sin_next = -c;
                cos_next = s;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign res_sin   = sin_reg;
    assign res_cos   = cos_reg;

endmodule
